### sv/pps_pkg.sv
package pps_pkg;

  localparam int MaxTasks = 16;
  localparam int IdxW = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
  localparam int Leaves = 1 << IdxW;
  localparam int TimeW = 16;
  localparam int SlotW = 4;
  localparam int PriW = 8;
  localparam logic [TimeW-1:0] TimeMax = '1;

  typedef enum logic {
    KindLoad = 1'b0,
    KindTick = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [SlotW-1:0]  slot_index;
    logic [TimeW-1:0]  arrival_time;
    logic [TimeW-1:0]  burst_time;
    logic [PriW-1:0]   priority_level;
  } in_word_t;

  typedef struct packed {
    logic [SlotW-1:0]  chosen_slot;
    logic              idle;
    logic              finished;
    logic [TimeW-1:0]  turnaround;
    logic [TimeW-1:0]  waiting;
  } out_word_t;

  typedef struct packed {
    logic              vld;
    logic [PriW-1:0]   pri;
    logic [IdxW-1:0]   idx;
    logic [TimeW-1:0]  arrival;
    logic [TimeW-1:0]  burst;
    logic [TimeW-1:0]  remaining;
  } cand_t;

endpackage

### sv/preemptive_priority_scheduler_unit.sv
// Preemptive priority scheduler with a table of task slots. One word is taken on every
// cycle that start_i is high (busy_o is always low). A load word fills a slot and gives no
// result; a tick word gives exactly one result word, strobed on result_valid_o for a single
// cycle once the tick has passed the input register and then the result register. The
// receiver cannot stall the block, so results must be captured on the cycle
// they appear. The selection is a parallel minimum tree over all slots between the input
// register and the result register.
module preemptive_priority_scheduler_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  pps_pkg::in_word_t   in_word_i,
  output logic                busy_o,
  output logic                result_valid_o,
  output pps_pkg::out_word_t  result_o
);

  logic                         in_valid_q;
  pps_pkg::in_word_t            in_word_q;
  logic [pps_pkg::MaxTasks-1:0] valid_q;
  logic [pps_pkg::MaxTasks-1:0] done_q;
  logic [pps_pkg::TimeW-1:0]    arrival_q   [pps_pkg::MaxTasks];
  logic [pps_pkg::TimeW-1:0]    burst_q     [pps_pkg::MaxTasks];
  logic [pps_pkg::PriW-1:0]     pri_q       [pps_pkg::MaxTasks];
  logic [pps_pkg::TimeW-1:0]    remaining_q [pps_pkg::MaxTasks];
  logic [pps_pkg::TimeW-1:0]    time_q;
  logic [pps_pkg::TimeW-1:0]    time_d;
  logic                         res_valid_q;
  pps_pkg::out_word_t           res_q;
  pps_pkg::out_word_t           res_d;

  pps_pkg::cand_t               cand [pps_pkg::MaxTasks];
  pps_pkg::cand_t               win;
  logic                         is_load;
  logic                         is_tick;
  logic [pps_pkg::TimeW-1:0]    rem_next;
  logic                         fin;
  logic [pps_pkg::TimeW:0]      ta_full;
  logic [pps_pkg::TimeW-1:0]    ta;

  assign busy_o = 1'b0;
  assign is_load = in_valid_q && (in_word_q.kind == pps_pkg::KindLoad);
  assign is_tick = in_valid_q && (in_word_q.kind == pps_pkg::KindTick);

  always_comb begin
    for (int i = 0; i < pps_pkg::MaxTasks; i++) begin
      cand[i].vld       = valid_q[i] && !done_q[i] && (arrival_q[i] <= time_q);
      cand[i].pri       = pri_q[i];
      cand[i].idx       = pps_pkg::IdxW'(i);
      cand[i].arrival   = arrival_q[i];
      cand[i].burst     = burst_q[i];
      cand[i].remaining = remaining_q[i];
    end
  end

  pps_select u_select (
    .cand_i (cand),
    .win_o  (win)
  );

  always_comb begin
    rem_next = (win.remaining != '0) ? win.remaining - 1'b1 : win.remaining;
    fin      = win.vld && (rem_next == '0);
    ta_full  = {1'b0, time_q} + 1'b1 - {1'b0, win.arrival};
    ta       = ta_full[pps_pkg::TimeW] ? pps_pkg::TimeMax : ta_full[pps_pkg::TimeW-1:0];
    time_d   = (time_q == pps_pkg::TimeMax) ? time_q : time_q + 1'b1;
    res_d             = '0;
    res_d.idle        = !win.vld;
    if (win.vld) begin
      res_d.chosen_slot = pps_pkg::SlotW'(32'(win.idx));
      res_d.finished    = fin;
      if (fin) begin
        res_d.turnaround = ta;
        res_d.waiting    = (ta >= win.burst) ? ta - win.burst : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      valid_q     <= '0;
      done_q      <= '0;
      time_q      <= '0;
    end else begin
      in_valid_q  <= start_i;
      res_valid_q <= is_tick;
      if (is_tick) begin
        time_q <= time_d;
      end
      for (int i = 0; i < pps_pkg::MaxTasks; i++) begin
        if (is_load && (32'(in_word_q.slot_index) == i)) begin
          valid_q[i] <= 1'b1;
          done_q[i]  <= 1'b0;
        end else if (is_tick && win.vld && (win.idx == pps_pkg::IdxW'(i))) begin
          done_q[i] <= fin;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      in_word_q <= in_word_i;
    end
    if (is_tick) begin
      res_q <= res_d;
    end
    for (int i = 0; i < pps_pkg::MaxTasks; i++) begin
      if (is_load && (32'(in_word_q.slot_index) == i)) begin
        arrival_q[i]   <= in_word_q.arrival_time;
        burst_q[i]     <= in_word_q.burst_time;
        pri_q[i]       <= in_word_q.priority_level;
        remaining_q[i] <= in_word_q.burst_time;
      end else if (is_tick && win.vld && (win.idx == pps_pkg::IdxW'(i))) begin
        remaining_q[i] <= rem_next;
      end
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

### sv/pps_select.sv
module pps_select (
  input  pps_pkg::cand_t cand_i [pps_pkg::MaxTasks],
  output pps_pkg::cand_t win_o
);

  pps_pkg::cand_t node [2*pps_pkg::Leaves];

  // Heap-ordered tree: the left child always holds the lower slots, so a tie keeps the left.
  always_comb begin
    for (int i = 0; i < 2*pps_pkg::Leaves; i++) begin
      node[i] = '0;
    end
    for (int i = 0; i < pps_pkg::MaxTasks; i++) begin
      node[pps_pkg::Leaves + i] = cand_i[i];
    end
    for (int i = pps_pkg::Leaves - 1; i >= 1; i--) begin
      if (node[2*i+1].vld && (!node[2*i].vld || (node[2*i+1].pri < node[2*i].pri))) begin
        node[i] = node[2*i+1];
      end else begin
        node[i] = node[2*i];
      end
    end
  end

  assign win_o = node[1];

endmodule

### tb/tb_preemptive_priority_scheduler_unit.sv
module tb_preemptive_priority_scheduler_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned RandomWords = 1500;
  localparam int unsigned PrintCap = 40;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  pps_pkg::in_word_t  in_word_i = '0;
  logic               busy_o;
  logic               result_valid_o;
  pps_pkg::out_word_t result_o;

  preemptive_priority_scheduler_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .in_word_i     (in_word_i),
    .busy_o        (busy_o),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  pps_pkg::in_word_t  word_queue[$];
  pps_pkg::out_word_t sched_expect[$];
  int unsigned err_count = 0;
  int unsigned words_sent = 0;
  int unsigned calm_from = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_left = 0;
  bit          noisy = 1'b1;
  bit          word_taken = 1'b0;
  logic [pps_pkg::TimeW-1:0] gen_time = '0;

  // Shadow copy of the task table.
  bit                        slot_valid[pps_pkg::MaxTasks];
  bit                        slot_done[pps_pkg::MaxTasks];
  logic [pps_pkg::TimeW-1:0] slot_arrival[pps_pkg::MaxTasks];
  logic [pps_pkg::TimeW-1:0] slot_burst[pps_pkg::MaxTasks];
  logic [pps_pkg::PriW-1:0]  slot_pri[pps_pkg::MaxTasks];
  logic [pps_pkg::TimeW-1:0] slot_left[pps_pkg::MaxTasks];
  logic [pps_pkg::TimeW-1:0] sched_now = '0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what);
    err_count++;
    if (err_count <= PrintCap) $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  task automatic check_result(input pps_pkg::out_word_t got, input pps_pkg::out_word_t exp);
    if (got.chosen_slot !== exp.chosen_slot)
      flag_mismatch($sformatf("chosen_slot %0d, expected %0d", got.chosen_slot, exp.chosen_slot));
    if (got.idle !== exp.idle)
      flag_mismatch($sformatf("idle %0b, expected %0b", got.idle, exp.idle));
    if (got.finished !== exp.finished)
      flag_mismatch($sformatf("finished %0b, expected %0b", got.finished, exp.finished));
    if (got.turnaround !== exp.turnaround)
      flag_mismatch($sformatf("turnaround %0d, expected %0d", got.turnaround, exp.turnaround));
    if (got.waiting !== exp.waiting)
      flag_mismatch($sformatf("waiting %0d, expected %0d", got.waiting, exp.waiting));
  endtask

  task automatic schedule_word(input pps_pkg::in_word_t w);
    bit                        found;
    int                        best;
    logic [pps_pkg::PriW-1:0]  best_pri;
    logic [pps_pkg::TimeW:0]   ta;
    logic [pps_pkg::TimeW-1:0] wt;
    pps_pkg::out_word_t        r;
    found = 1'b0;
    best = 0;
    best_pri = '0;
    ta = '0;
    wt = '0;
    r = '0;
    if (w.kind == pps_pkg::KindLoad) begin
      if (int'(w.slot_index) < pps_pkg::MaxTasks) begin
        slot_valid[w.slot_index] = 1'b1;
        slot_done[w.slot_index] = 1'b0;
        slot_arrival[w.slot_index] = w.arrival_time;
        slot_burst[w.slot_index] = w.burst_time;
        slot_pri[w.slot_index] = w.priority_level;
        slot_left[w.slot_index] = w.burst_time;
      end
    end else begin
      for (int i = 0; i < pps_pkg::MaxTasks; i++) begin
        if (slot_valid[i] && !slot_done[i] && slot_arrival[i] <= sched_now &&
            (!found || slot_pri[i] < best_pri)) begin
          found = 1'b1;
          best = i;
          best_pri = slot_pri[i];
        end
      end
      if (!found) begin
        r.idle = 1'b1;
      end else begin
        if (slot_left[best] != '0) slot_left[best] = slot_left[best] - 1'b1;
        if (slot_left[best] == '0) begin
          slot_done[best] = 1'b1;
          r.finished = 1'b1;
          ta = {1'b0, sched_now} + 1'b1 - {1'b0, slot_arrival[best]};
          if (ta > {1'b0, pps_pkg::TimeMax}) ta = {1'b0, pps_pkg::TimeMax};
          wt = (ta >= {1'b0, slot_burst[best]}) ?
               pps_pkg::TimeW'(ta - slot_burst[best]) : '0;
          r.turnaround = ta[pps_pkg::TimeW-1:0];
          r.waiting = wt;
        end
        r.chosen_slot = pps_pkg::SlotW'(best);
      end
      sched_expect = {sched_expect, r};
      if (sched_now != pps_pkg::TimeMax) sched_now = sched_now + 1'b1;
    end
  endtask

  task automatic push_load(input int slot, input logic [pps_pkg::TimeW-1:0] arr,
                           input logic [pps_pkg::TimeW-1:0] burst,
                           input logic [pps_pkg::PriW-1:0] pri);
    pps_pkg::in_word_t w;
    w.kind = pps_pkg::KindLoad;
    w.slot_index = pps_pkg::SlotW'(slot);
    w.arrival_time = arr;
    w.burst_time = burst;
    w.priority_level = pri;
    word_queue = {word_queue, w};
  endtask

  task automatic push_tick();
    pps_pkg::in_word_t w;
    w.kind = pps_pkg::KindTick;
    w.slot_index = pps_pkg::SlotW'($urandom());
    w.arrival_time = pps_pkg::TimeW'($urandom());
    w.burst_time = pps_pkg::TimeW'($urandom());
    w.priority_level = pps_pkg::PriW'($urandom());
    word_queue = {word_queue, w};
    if (gen_time != pps_pkg::TimeMax) gen_time = gen_time + 1'b1;
  endtask

  function automatic logic [pps_pkg::TimeW-1:0] near_time(
      input logic [pps_pkg::TimeW-1:0] base, input int off);
    logic [pps_pkg::TimeW:0] sum;
    sum = {1'b0, base} + pps_pkg::TimeW'(off);
    return (sum > {1'b0, pps_pkg::TimeMax}) ? pps_pkg::TimeMax : sum[pps_pkg::TimeW-1:0];
  endfunction

  task automatic build_random_words();
    int unsigned               r;
    logic [pps_pkg::TimeW-1:0] arr;
    logic [pps_pkg::TimeW-1:0] burst;
    logic [pps_pkg::PriW-1:0]  pri;
    int unsigned               target;
    target = word_queue.size() + RandomWords;
    while (word_queue.size() < target) begin
      if ($urandom_range(0, 9) < 4) begin
        r = $urandom_range(0, 9);
        if (r < 7) arr = near_time(gen_time, $urandom_range(0, 8));
        else if (r < 9) arr = pps_pkg::TimeW'($urandom_range(0, gen_time));
        else arr = pps_pkg::TimeW'($urandom());
        r = $urandom_range(0, 99);
        if (r < 80) burst = pps_pkg::TimeW'($urandom_range(1, 6));
        else if (r < 95) burst = pps_pkg::TimeW'($urandom_range(7, 50));
        else if (r < 99) burst = pps_pkg::TimeW'($urandom_range(1, 65535));
        else burst = '0;
        pri = ($urandom_range(0, 1) == 0) ? pps_pkg::PriW'($urandom_range(0, 3)) :
              pps_pkg::PriW'($urandom());
        push_load($urandom_range(0, pps_pkg::MaxTasks - 1), arr, burst, pri);
      end else begin
        push_tick();
      end
    end
  endtask

  initial begin
    for (int i = 0; i < pps_pkg::MaxTasks; i++) begin
      slot_valid[i] = 1'b0;
      slot_done[i] = 1'b0;
    end

    push_tick();
    push_load(0, 16'd0, 16'd1, 8'hFF);
    push_load(15, 16'd2, 16'd2, 8'd0);
    push_tick();
    push_tick();
    push_load(7, 16'd0, 16'd0, 8'd0);
    push_tick();
    push_tick();
    push_load(3, pps_pkg::TimeMax, 16'hFFFF, 8'h80);
    push_load(4, 16'd5, 16'd3, 8'd5);
    push_load(4, 16'd5, 16'd2, 8'd5);
    push_load(5, 16'd0, 16'd3, 8'd9);
    push_tick();
    push_load(6, 16'd0, 16'd1, 8'd1);
    push_tick();
    push_tick();
    push_tick();
    push_tick();
    push_tick();
    push_tick();
    push_tick();

    build_random_words();

    calm_from = word_queue.size();
    push_load(0, 16'd0, 16'hFFFF, 8'hFF);
    push_load(1, 16'hFFFA, 16'd10, 8'd0);
    push_load(2, pps_pkg::TimeMax, 16'd7, 8'd0);
    push_load(8, 16'd0, 16'd3, 8'd1);
    repeat (20) push_tick();

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    do @(negedge clk_i); while (word_queue.size() != 0 || start_i);
    while (sched_expect.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    if (sched_expect.size() != 0) flag_mismatch("result words missing at the end");

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (!start_i || word_taken) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start_i <= 1'b0;
      end else if (word_queue.size() != 0) begin
        if (words_sent < calm_from && noisy && $urandom_range(0, 9) == 0) begin
          gap_left <= $urandom_range(0, 11);
          start_i <= 1'b0;
        end else begin
          in_word_i <= word_queue.pop_front();
          start_i <= 1'b1;
          words_sent <= words_sent + 1;
          if (words_sent % 50 == 0) noisy <= ($urandom_range(0, 2) != 0);
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      word_taken <= 1'b0;
    end else begin
      if (result_valid_o) begin
        if (sched_expect.size() == 0) flag_mismatch("result word with none expected");
        else check_result(result_o, sched_expect.pop_front());
      end
      if (start_i && !busy_o) begin
        schedule_word(in_word_i);
        word_taken <= 1'b1;
      end else begin
        word_taken <= 1'b0;
      end
    end
  end

endmodule

### filelist.f
sv/pps_pkg.sv
sv/pps_select.sv
sv/preemptive_priority_scheduler_unit.sv
tb/tb_preemptive_priority_scheduler_unit.sv
